// File: sv/stok_pkg.sv
// stok_pkg: shared types, codes and character classes for the s-expression tokenizer
// no dependencies; used by sexpr_tokenizer_top and the testbench
`timescale 1ns / 1ps
`default_nettype none

package stok_pkg;

    localparam int MAX_TOKEN_BYTES = 1024;
    localparam int LEN_W           = $clog2(MAX_TOKEN_BYTES);
    localparam int LEN_LIMIT       = MAX_TOKEN_BYTES - 1;

    // result queue
    localparam int RQ_DEPTH  = 4;
    localparam int RQ_PTR_W  = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_W  = $clog2(RQ_DEPTH + 1);
    localparam int MAX_RES   = 3;
    localparam int RES_CNT_W = $clog2(MAX_RES + 1);

    localparam logic [2:0] KIND_LPAREN = 3'd0;
    localparam logic [2:0] KIND_RPAREN = 3'd1;
    localparam logic [2:0] KIND_QUOTE  = 3'd2;
    localparam logic [2:0] KIND_SYMBOL = 3'd3;
    localparam logic [2:0] KIND_NUMBER = 3'd4;
    localparam logic [2:0] KIND_BOOL   = 3'd5;
    localparam logic [2:0] KIND_STRING = 3'd6;
    localparam logic [2:0] KIND_END    = 3'd7;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_BAD_BOOL   = 3'd1;
    localparam logic [2:0] ERR_UNTERM_STR = 3'd2;
    localparam logic [2:0] ERR_UNEXPECTED = 3'd3;
    localparam logic [2:0] ERR_TOO_LONG   = 3'd4;

    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_F      = 8'h66;

    typedef enum logic [6:0] {
        MODE_IDLE    = 7'b0000001,
        MODE_COMMENT = 7'b0000010,
        MODE_HASH    = 7'b0000100,
        MODE_MINUS   = 7'b0001000,
        MODE_NUMBER  = 7'b0010000,
        MODE_SYMBOL  = 7'b0100000,
        MODE_STRING  = 7'b1000000
    } lex_mode_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] text;
        logic       has;
        logic       tend;
        logic [2:0] err;
    } tok_res_t;

    function automatic tok_res_t mk_res(logic [2:0] kind, logic [7:0] text, logic has,
                                        logic tend, logic [2:0] err);
        tok_res_t r;
        r.kind = kind;
        r.text = text;
        r.has  = has;
        r.tend = tend;
        r.err  = err;
        return r;
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return c inside {8'h20, [8'h09:8'h0D]};
    endfunction

    function automatic logic is_print(logic [7:0] c);
        return c inside {[8'h20:8'h7E]};
    endfunction

    // + - * / < = > ! ? _
    function automatic logic is_sym(logic [7:0] c);
        return c inside {8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h3C, 8'h3D, 8'h3E, 8'h21, 8'h3F, 8'h5F};
    endfunction

    function automatic logic continues(logic num, logic [7:0] c);
        logic r;
        if (num)
        begin
            r = is_digit(c) || (c == CH_DOT) || (c == CH_SLASH);
        end
        else
        begin
            r = is_alpha(c) || is_digit(c) || is_sym(c);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: sv/stok_if.sv
// stok_if: valid/ready channel interfaces for source bytes and tokens
// standalone; used by sexpr_tokenizer_top
`timescale 1ns / 1ps
`default_nettype none

interface stok_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       end_of_input;

    modport source (output valid, output char_byte, output end_of_input, input ready);
    modport sink   (input valid, input char_byte, input end_of_input, output ready);
endinterface

interface stok_token_if;
    logic       valid;
    logic       ready;
    logic [2:0] token_kind;
    logic [7:0] text_byte;
    logic       has_byte;
    logic       token_end;
    logic [2:0] error_code;

    modport source (output valid, output token_kind, output text_byte, output has_byte,
                    output token_end, output error_code, input ready);
    modport sink   (input valid, input token_kind, input text_byte, input has_byte,
                    input token_end, input error_code, output ready);
endinterface

`default_nettype wire

// File: sv/sexpr_tokenizer_top.sv
// sexpr_tokenizer_top: streaming s-expression lexer, one source byte per input beat
// depends on stok_pkg and the channel interfaces in stok_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Takes one source byte (or an end-of-input mark) per beat on char_in and emits token
// results on token_out, one result per beat. A byte is latched in an input register, lexed
// combinationally against the lexer mode and token length, and its zero to three results
// are written into a four-entry result queue that drains one result per cycle while
// token_out is ready. The input side takes a byte every cycle while each byte yields at most
// one result and token_out is ready; a byte that yields two or three results takes one output
// beat per result, and the input stalls while the queue holds more than one result. Tokens
// longer than MAX_TOKEN_BYTES-1 text bytes are cut with a too-long error.
module sexpr_tokenizer_top
    import stok_pkg::*;
(
    input  wire           clk,
    input  wire           rst_n,
    stok_char_if.sink     char_in,
    stok_token_if.source  token_out
);

    // input register
    logic       in_vld_reg;
    logic [7:0] in_byte_reg;
    logic       in_eoi_reg;
    logic       consume;
    logic       accept;

    // lexer state
    lex_mode_t        mode_reg, mode_next;
    logic [LEN_W-1:0] len_reg, len_next;

    // step results
    tok_res_t             step_res [MAX_RES];
    logic [RES_CNT_W-1:0] step_cnt;
    logic                 do_cont;
    logic                 do_idle;
    logic [2:0]           cont_kind;
    logic [7:0]           c;
    logic                 eoi;

    // result queue
    tok_res_t              rq_reg [RQ_DEPTH];
    logic [RQ_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [RQ_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                  pop;

    assign consume       = in_vld_reg && (cnt_reg <= RQ_CNT_W'(1));
    assign char_in.ready = !in_vld_reg || consume;
    assign accept        = char_in.valid && char_in.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (consume)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= char_in.char_byte;
            in_eoi_reg  <= char_in.end_of_input;
        end
    end

    assign c   = in_byte_reg;
    assign eoi = in_eoi_reg;

    always_comb
    begin
        mode_next = mode_reg;
        len_next  = len_reg;
        step_cnt  = '0;
        do_cont   = 1'b0;
        do_idle   = 1'b0;
        cont_kind = KIND_SYMBOL;
        for (int i = 0; i < MAX_RES; i++)
        begin
            step_res[i] = '0;
        end

        case (mode_reg)
            MODE_COMMENT:
            begin
                if (eoi)
                begin
                    mode_next = MODE_IDLE;
                    step_res[step_cnt] = mk_res(KIND_END, 8'h00, 1'b0, 1'b1, ERR_NONE);
                    step_cnt = step_cnt + 1'b1;
                end
                else if (c == CH_LF)
                begin
                    mode_next = MODE_IDLE;
                end
            end
            MODE_HASH:
            begin
                mode_next = MODE_IDLE;
                if (eoi)
                begin
                    step_res[step_cnt] = mk_res(KIND_BOOL, 8'h00, 1'b0, 1'b1, ERR_BAD_BOOL);
                    step_cnt = step_cnt + 1'b1;
                    step_res[step_cnt] = mk_res(KIND_END, 8'h00, 1'b0, 1'b1, ERR_NONE);
                    step_cnt = step_cnt + 1'b1;
                end
                else if (c == CH_T || c == CH_F)
                begin
                    step_res[step_cnt] = mk_res(KIND_BOOL, c, 1'b1, 1'b1, ERR_NONE);
                    step_cnt = step_cnt + 1'b1;
                end
                else
                begin
                    step_res[step_cnt] = mk_res(KIND_BOOL, c, 1'b1, 1'b1, ERR_BAD_BOOL);
                    step_cnt = step_cnt + 1'b1;
                end
            end
            MODE_MINUS:
            begin
                // the held minus is always the first text byte, so it never overflows
                len_next = LEN_W'(1);
                if (!eoi && is_digit(c))
                begin
                    mode_next = MODE_NUMBER;
                    step_res[step_cnt] = mk_res(KIND_NUMBER, CH_MINUS, 1'b1, 1'b0, ERR_NONE);
                    step_cnt = step_cnt + 1'b1;
                    if (len_next >= LEN_W'(LEN_LIMIT))
                    begin
                        step_res[step_cnt] = mk_res(KIND_NUMBER, 8'h00, 1'b0, 1'b1,
                                                    ERR_TOO_LONG);
                        step_cnt  = step_cnt + 1'b1;
                        mode_next = MODE_IDLE;
                        len_next  = '0;
                    end
                    else
                    begin
                        step_res[step_cnt] = mk_res(KIND_NUMBER, c, 1'b1, 1'b0, ERR_NONE);
                        step_cnt = step_cnt + 1'b1;
                        len_next = len_next + 1'b1;
                    end
                end
                else
                begin
                    mode_next = MODE_SYMBOL;
                    step_res[step_cnt] = mk_res(KIND_SYMBOL, CH_MINUS, 1'b1, 1'b0, ERR_NONE);
                    step_cnt  = step_cnt + 1'b1;
                    do_cont   = 1'b1;
                    cont_kind = KIND_SYMBOL;
                end
            end
            MODE_NUMBER:
            begin
                do_cont   = 1'b1;
                cont_kind = KIND_NUMBER;
            end
            MODE_SYMBOL:
            begin
                do_cont   = 1'b1;
                cont_kind = KIND_SYMBOL;
            end
            MODE_STRING:
            begin
                if (eoi)
                begin
                    mode_next = MODE_IDLE;
                    len_next  = '0;
                    step_res[step_cnt] = mk_res(KIND_STRING, 8'h00, 1'b0, 1'b1,
                                                ERR_UNTERM_STR);
                    step_cnt = step_cnt + 1'b1;
                    step_res[step_cnt] = mk_res(KIND_END, 8'h00, 1'b0, 1'b1, ERR_NONE);
                    step_cnt = step_cnt + 1'b1;
                end
                else if (c == CH_DQUOTE)
                begin
                    mode_next = MODE_IDLE;
                    len_next  = '0;
                    step_res[step_cnt] = mk_res(KIND_STRING, 8'h00, 1'b0, 1'b1, ERR_NONE);
                    step_cnt = step_cnt + 1'b1;
                end
                else if (is_print(c))
                begin
                    if (len_next >= LEN_W'(LEN_LIMIT))
                    begin
                        step_res[step_cnt] = mk_res(KIND_STRING, 8'h00, 1'b0, 1'b1,
                                                    ERR_TOO_LONG);
                        step_cnt  = step_cnt + 1'b1;
                        mode_next = MODE_IDLE;
                        len_next  = '0;
                    end
                    else
                    begin
                        step_res[step_cnt] = mk_res(KIND_STRING, c, 1'b1, 1'b0, ERR_NONE);
                        step_cnt = step_cnt + 1'b1;
                        len_next = len_next + 1'b1;
                    end
                end
                else
                begin
                    mode_next = MODE_IDLE;
                    len_next  = '0;
                    step_res[step_cnt] = mk_res(KIND_STRING, 8'h00, 1'b0, 1'b1,
                                                ERR_UNTERM_STR);
                    step_cnt = step_cnt + 1'b1;
                end
            end
            default:
            begin
                mode_next = MODE_IDLE;
                len_next  = '0;
                if (eoi)
                begin
                    step_res[step_cnt] = mk_res(KIND_END, 8'h00, 1'b0, 1'b1, ERR_NONE);
                    step_cnt = step_cnt + 1'b1;
                end
                else
                begin
                    do_idle = 1'b1;
                end
            end
        endcase

        // extend a number or symbol (cut when full), or close it and relex the byte from idle
        if (do_cont)
        begin
            if (!eoi && continues(cont_kind == KIND_NUMBER, c))
            begin
                if (len_next >= LEN_W'(LEN_LIMIT))
                begin
                    step_res[step_cnt] = mk_res(cont_kind, 8'h00, 1'b0, 1'b1, ERR_TOO_LONG);
                    step_cnt  = step_cnt + 1'b1;
                    mode_next = MODE_IDLE;
                    len_next  = '0;
                end
                else
                begin
                    step_res[step_cnt] = mk_res(cont_kind, c, 1'b1, 1'b0, ERR_NONE);
                    step_cnt = step_cnt + 1'b1;
                    len_next = len_next + 1'b1;
                end
            end
            else
            begin
                step_res[step_cnt] = mk_res(cont_kind, 8'h00, 1'b0, 1'b1, ERR_NONE);
                step_cnt  = step_cnt + 1'b1;
                mode_next = MODE_IDLE;
                len_next  = '0;
                if (eoi)
                begin
                    step_res[step_cnt] = mk_res(KIND_END, 8'h00, 1'b0, 1'b1, ERR_NONE);
                    step_cnt = step_cnt + 1'b1;
                end
                else
                begin
                    do_idle = 1'b1;
                end
            end
        end

        if (do_idle)
        begin
            mode_next = MODE_IDLE;
            len_next  = '0;
            if (is_space(c))
            begin
                mode_next = MODE_IDLE;
            end
            else if (c == CH_LPAREN)
            begin
                step_res[step_cnt] = mk_res(KIND_LPAREN, 8'h00, 1'b0, 1'b1, ERR_NONE);
                step_cnt = step_cnt + 1'b1;
            end
            else if (c == CH_RPAREN)
            begin
                step_res[step_cnt] = mk_res(KIND_RPAREN, 8'h00, 1'b0, 1'b1, ERR_NONE);
                step_cnt = step_cnt + 1'b1;
            end
            else if (c == CH_QUOTE)
            begin
                step_res[step_cnt] = mk_res(KIND_QUOTE, 8'h00, 1'b0, 1'b1, ERR_NONE);
                step_cnt = step_cnt + 1'b1;
            end
            else if (c == CH_SEMI)
            begin
                mode_next = MODE_COMMENT;
            end
            else if (c == CH_HASH)
            begin
                mode_next = MODE_HASH;
            end
            else if (c == CH_MINUS)
            begin
                mode_next = MODE_MINUS;
            end
            else if (c == CH_DQUOTE)
            begin
                mode_next = MODE_STRING;
            end
            else if (is_digit(c) || is_alpha(c) || is_sym(c))
            begin
                // first text byte of a fresh token always fits
                mode_next = is_digit(c) ? MODE_NUMBER : MODE_SYMBOL;
                step_res[step_cnt] = mk_res(is_digit(c) ? KIND_NUMBER : KIND_SYMBOL, c, 1'b1,
                                            1'b0, ERR_NONE);
                step_cnt = step_cnt + 1'b1;
                len_next = LEN_W'(1);
            end
            else
            begin
                step_res[step_cnt] = mk_res(KIND_LPAREN, c, 1'b1, 1'b1, ERR_UNEXPECTED);
                step_cnt = step_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            len_reg  <= '0;
        end
        else if (consume)
        begin
            mode_reg <= mode_next;
            len_reg  <= len_next;
        end
    end

    // result queue, one result per output beat
    assign pop      = token_out.valid && token_out.ready;
    assign cnt_next = cnt_reg + (consume ? RQ_CNT_W'(step_cnt) : RQ_CNT_W'(0))
                      - RQ_CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (consume)
            begin
                wr_ptr_reg <= wr_ptr_reg + RQ_PTR_W'(step_cnt);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RES; i++)
        begin
            if (consume && (RES_CNT_W'(i) < step_cnt))
            begin
                rq_reg[wr_ptr_reg + RQ_PTR_W'(i)] <= step_res[i];
            end
        end
    end

    assign token_out.valid      = (cnt_reg != '0);
    assign token_out.token_kind = rq_reg[rd_ptr_reg].kind;
    assign token_out.text_byte  = rq_reg[rd_ptr_reg].text;
    assign token_out.has_byte   = rq_reg[rd_ptr_reg].has;
    assign token_out.token_end  = rq_reg[rd_ptr_reg].tend;
    assign token_out.error_code = rq_reg[rd_ptr_reg].err;

endmodule

`default_nettype wire

// File: dv/testbench.sv
// testbench: self-checking bench for sexpr_tokenizer_top, driving source bytes and
// checking every token result against an in-bench lexer prediction
// depends on stok_pkg, stok_if.sv and sexpr_tokenizer_top
`timescale 1ns / 1ps

module testbench
    import stok_pkg::*;
();

    localparam int IDLE_LIMIT  = 4000;
    localparam int LONG_HOLD   = 400;
    localparam int CHUNK_ITEMS = 18;
    localparam string SYM_SET  = "+-*/<=>!?_";

    typedef struct {
        logic [7:0] ch;
        logic       eoi;
    } src_item_t;

    logic clk = 1'b0;
    logic rst_n;

    stok_char_if  char_bus ();
    stok_token_if tok_bus ();

    sexpr_tokenizer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_in   (char_bus),
        .token_out (tok_bus)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    src_item_t   char_pending[$];
    tok_res_t    tok_expected[$];

    // lexer prediction state
    lex_mode_t   lx_mode;
    int unsigned lx_len;
    int          step_cnt;

    int beats_sent;
    int eoi_sent;
    int results_seen;
    int err_results;
    int mismatches;
    int stall_requests;

    // ---------------- lexer prediction ----------------

    function automatic logic digit_ch(logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic letter_ch(logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic blank_ch(logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic logic printable_ch(logic [7:0] c);
        return (c >= 8'h20) && (c <= 8'h7E);
    endfunction

    function automatic logic sym_ch(logic [7:0] c);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < SYM_SET.len(); i++)
        begin
            if (SYM_SET[i] == c)
            begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic logic extends_tok(logic [2:0] kind, logic [7:0] c);
        if (kind == KIND_NUMBER)
        begin
            return digit_ch(c) || (c == CH_DOT) || (c == CH_SLASH);
        end
        return letter_ch(c) || digit_ch(c) || sym_ch(c);
    endfunction

    function automatic void emit_tok(logic [2:0] kind, logic [7:0] text, logic has,
                                     logic tend, logic [2:0] err);
        tok_res_t r;
        if (step_cnt >= MAX_RES)
        begin
            return;
        end
        r.kind = kind;
        r.text = text;
        r.has  = has;
        r.tend = tend;
        r.err  = err;
        tok_expected.push_back(r);
        step_cnt++;
    endfunction

    // one text byte, or the too-long cut once the token is full
    function automatic logic add_text(logic [2:0] kind, logic [7:0] c);
        if (lx_len >= MAX_TOKEN_BYTES - 1)
        begin
            emit_tok(kind, 8'h00, 1'b0, 1'b1, ERR_TOO_LONG);
            lx_mode = MODE_IDLE;
            lx_len  = 0;
            return 1'b0;
        end
        emit_tok(kind, c, 1'b1, 1'b0, ERR_NONE);
        lx_len++;
        return 1'b1;
    endfunction

    function automatic void start_token(logic [7:0] c);
        lx_mode = MODE_IDLE;
        lx_len  = 0;
        if (blank_ch(c))
        begin
            return;
        end
        case (c)
            CH_LPAREN: emit_tok(KIND_LPAREN, 8'h00, 1'b0, 1'b1, ERR_NONE);
            CH_RPAREN: emit_tok(KIND_RPAREN, 8'h00, 1'b0, 1'b1, ERR_NONE);
            CH_QUOTE:  emit_tok(KIND_QUOTE, 8'h00, 1'b0, 1'b1, ERR_NONE);
            CH_SEMI:   lx_mode = MODE_COMMENT;
            CH_HASH:   lx_mode = MODE_HASH;
            CH_MINUS:  lx_mode = MODE_MINUS;
            CH_DQUOTE: lx_mode = MODE_STRING;
            default:
            begin
                if (digit_ch(c))
                begin
                    lx_mode = MODE_NUMBER;
                    void'(add_text(KIND_NUMBER, c));
                end
                else if (letter_ch(c) || sym_ch(c))
                begin
                    lx_mode = MODE_SYMBOL;
                    void'(add_text(KIND_SYMBOL, c));
                end
                else
                begin
                    emit_tok(KIND_LPAREN, c, 1'b1, 1'b1, ERR_UNEXPECTED);
                end
            end
        endcase
    endfunction

    // a byte that cannot extend the token closes it and is lexed again from idle
    function automatic void close_or_extend(logic [2:0] kind, logic eoi, logic [7:0] c);
        if (!eoi && extends_tok(kind, c))
        begin
            void'(add_text(kind, c));
            return;
        end
        emit_tok(kind, 8'h00, 1'b0, 1'b1, ERR_NONE);
        lx_mode = MODE_IDLE;
        lx_len  = 0;
        if (eoi)
        begin
            emit_tok(KIND_END, 8'h00, 1'b0, 1'b1, ERR_NONE);
        end
        else
        begin
            start_token(c);
        end
    endfunction

    function automatic void lex_predict(logic [7:0] c, logic eoi);
        step_cnt = 0;
        case (lx_mode)
            MODE_COMMENT:
            begin
                if (eoi)
                begin
                    lx_mode = MODE_IDLE;
                    emit_tok(KIND_END, 8'h00, 1'b0, 1'b1, ERR_NONE);
                end
                else if (c == CH_LF)
                begin
                    lx_mode = MODE_IDLE;
                end
            end
            MODE_HASH:
            begin
                lx_mode = MODE_IDLE;
                if (eoi)
                begin
                    emit_tok(KIND_BOOL, 8'h00, 1'b0, 1'b1, ERR_BAD_BOOL);
                    emit_tok(KIND_END, 8'h00, 1'b0, 1'b1, ERR_NONE);
                end
                else if ((c == CH_T) || (c == CH_F))
                begin
                    emit_tok(KIND_BOOL, c, 1'b1, 1'b1, ERR_NONE);
                end
                else
                begin
                    emit_tok(KIND_BOOL, c, 1'b1, 1'b1, ERR_BAD_BOOL);
                end
            end
            MODE_MINUS:
            begin
                lx_len = 0;
                if (!eoi && digit_ch(c))
                begin
                    lx_mode = MODE_NUMBER;
                    if (add_text(KIND_NUMBER, CH_MINUS))
                    begin
                        void'(add_text(KIND_NUMBER, c));
                    end
                end
                else
                begin
                    lx_mode = MODE_SYMBOL;
                    if (add_text(KIND_SYMBOL, CH_MINUS))
                    begin
                        close_or_extend(KIND_SYMBOL, eoi, c);
                    end
                end
            end
            MODE_NUMBER: close_or_extend(KIND_NUMBER, eoi, c);
            MODE_SYMBOL: close_or_extend(KIND_SYMBOL, eoi, c);
            MODE_STRING:
            begin
                if (eoi)
                begin
                    lx_mode = MODE_IDLE;
                    lx_len  = 0;
                    emit_tok(KIND_STRING, 8'h00, 1'b0, 1'b1, ERR_UNTERM_STR);
                    emit_tok(KIND_END, 8'h00, 1'b0, 1'b1, ERR_NONE);
                end
                else if (c == CH_DQUOTE)
                begin
                    lx_mode = MODE_IDLE;
                    lx_len  = 0;
                    emit_tok(KIND_STRING, 8'h00, 1'b0, 1'b1, ERR_NONE);
                end
                else if (printable_ch(c))
                begin
                    void'(add_text(KIND_STRING, c));
                end
                else
                begin
                    lx_mode = MODE_IDLE;
                    lx_len  = 0;
                    emit_tok(KIND_STRING, 8'h00, 1'b0, 1'b1, ERR_UNTERM_STR);
                end
            end
            default:
            begin
                lx_mode = MODE_IDLE;
                lx_len  = 0;
                if (eoi)
                begin
                    emit_tok(KIND_END, 8'h00, 1'b0, 1'b1, ERR_NONE);
                end
                else
                begin
                    start_token(c);
                end
            end
        endcase
    endfunction

    // ---------------- source driver ----------------

    int tx_burst_left;
    int tx_gap_left;

    always @(posedge clk or negedge rst_n)
    begin : char_driver
        logic       nv;
        logic [7:0] nb;
        logic       ne;
        src_item_t  it;
        if (!rst_n)
        begin
            char_bus.valid        <= 1'b0;
            char_bus.char_byte    <= 8'h00;
            char_bus.end_of_input <= 1'b0;
            tx_burst_left = 0;
            tx_gap_left   = 0;
        end
        else
        begin
            nv = char_bus.valid;
            nb = char_bus.char_byte;
            ne = char_bus.end_of_input;
            if (char_bus.valid && char_bus.ready)
            begin
                lex_predict(char_bus.char_byte, char_bus.end_of_input);
                beats_sent++;
                if (char_bus.end_of_input)
                begin
                    eoi_sent++;
                end
                nv = 1'b0;
            end
            if (!nv)
            begin
                if (tx_gap_left > 0)
                begin
                    tx_gap_left--;
                end
                else if (char_pending.size() != 0)
                begin
                    it = char_pending.pop_front();
                    nv = 1'b1;
                    nb = it.ch;
                    ne = it.eoi;
                    if (tx_burst_left > 0)
                    begin
                        tx_burst_left--;
                    end
                    if (tx_burst_left == 0)
                    begin
                        // mostly short bursts, now and then a long unbroken stretch
                        tx_burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 100)
                                                                    : $urandom_range(1, 12);
                        tx_gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                    end
                end
            end
            char_bus.valid        <= nv;
            char_bus.char_byte    <= nb;
            char_bus.end_of_input <= ne;
        end
    end

    // ---------------- token receiver ----------------

    int rx_served;
    int rx_hold_left;
    int rx_phase_left;
    int rx_style;
    int rx_tick;

    always @(posedge clk or negedge rst_n)
    begin : token_receiver
        logic nr;
        if (!rst_n)
        begin
            tok_bus.ready <= 1'b0;
            rx_served     = 0;
            rx_hold_left  = 0;
            rx_phase_left = 0;
            rx_style      = 0;
            rx_tick       = 0;
        end
        else
        begin
            rx_tick++;
            if (rx_served != stall_requests)
            begin
                rx_served++;
                rx_hold_left = LONG_HOLD;
            end
            if (rx_hold_left > 0)
            begin
                rx_hold_left--;
                nr = 1'b0;
            end
            else
            begin
                if (rx_phase_left == 0)
                begin
                    rx_style      = $urandom_range(0, 3);
                    rx_phase_left = $urandom_range(8, 80);
                end
                rx_phase_left--;
                case (rx_style)
                    0:       nr = 1'b1;
                    1:       nr = 1'($urandom_range(0, 1));
                    2:       nr = (rx_tick % 3) == 0;
                    default: nr = $urandom_range(0, 7) != 0;
                endcase
            end
            tok_bus.ready <= nr;
        end
    end

    // ---------------- result checker ----------------

    always @(posedge clk)
    begin : token_checker
        tok_res_t got;
        tok_res_t want;
        logic     bad;
        if (rst_n && tok_bus.valid && tok_bus.ready)
        begin
            got.kind = tok_bus.token_kind;
            got.text = tok_bus.text_byte;
            got.has  = tok_bus.has_byte;
            got.tend = tok_bus.token_end;
            got.err  = tok_bus.error_code;
            results_seen++;
            if (got.err != ERR_NONE)
            begin
                err_results++;
            end
            if (tok_expected.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected result %0d: kind=%0d text=%02h has=%0d end=%0d err=%0d",
                             results_seen, got.kind, got.text, got.has, got.tend, got.err);
                end
            end
            else
            begin
                want = tok_expected.pop_front();
                bad  = (got.kind !== want.kind) || (got.text !== want.text) ||
                       (got.has !== want.has) || (got.tend !== want.tend) ||
                       (got.err !== want.err);
                if (bad)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch at result %0d: exp kind=%0d text=%02h has=%0d end=%0d err=%0d",
                                 results_seen, want.kind, want.text, want.has, want.tend,
                                 want.err);
                        $display("    got kind=%0d text=%02h has=%0d end=%0d err=%0d",
                                 got.kind, got.text, got.has, got.tend, got.err);
                    end
                end
            end
        end
    end

    // ---------------- watchdog ----------------

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (char_bus.valid && char_bus.ready) ||
                (tok_bus.valid && tok_bus.ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("timeout: no beat for %0d cycles, %0d results outstanding",
                 IDLE_LIMIT, tok_expected.size());
        $display("TB_ERROR");
        $finish;
    end

    // ---------------- stimulus ----------------

    function automatic void push_char(logic [7:0] c, logic eoi);
        src_item_t it;
        it.ch  = c;
        it.eoi = eoi;
        char_pending.push_back(it);
    endfunction

    function automatic logic [7:0] text_char_nq();
        logic [7:0] c;
        c = 8'($urandom_range(8'h20, 8'h7E));
        if (c == CH_DQUOTE)
        begin
            c = 8'h7E;
        end
        return c;
    endfunction

    function automatic logic [7:0] sym_body_char();
        int r;
        r = $urandom_range(0, 3);
        if (r == 0)
        begin
            return 8'(8'h30 + $urandom_range(0, 9));
        end
        if (r == 1)
        begin
            return SYM_SET[$urandom_range(0, SYM_SET.len() - 1)];
        end
        return 8'(($urandom_range(0, 1) ? 8'h61 : 8'h41) + $urandom_range(0, 25));
    endfunction

    task automatic wait_drained();
        while ((char_pending.size() != 0) || char_bus.valid || (tok_expected.size() != 0))
        begin
            @(negedge clk);
        end
    endtask

    initial
    begin : stimulus
        int         n;
        int         kind_sel;
        int         chunk_base;
        logic [7:0] c;

        char_bus.valid        = 1'b0;
        char_bus.char_byte    = 8'h00;
        char_bus.end_of_input = 1'b0;
        tok_bus.ready         = 1'b0;
        rst_n                 = 1'b0;
        lx_mode        = MODE_IDLE;
        lx_len         = 0;
        step_cnt       = 0;
        beats_sent     = 0;
        eoi_sent       = 0;
        results_seen   = 0;
        err_results    = 0;
        mismatches     = 0;
        stall_requests = 0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: single-byte tokens, booleans, held minus, closes, errors, end marks
        push_char(CH_LPAREN, 1'b0);
        push_char(CH_RPAREN, 1'b0);
        push_char(CH_QUOTE, 1'b0);
        push_char(CH_HASH, 1'b0);
        push_char(CH_T, 1'b0);
        push_char(CH_HASH, 1'b0);
        push_char(CH_F, 1'b0);
        push_char(CH_HASH, 1'b0);
        push_char("!", 1'b0);
        push_char(CH_MINUS, 1'b0);
        push_char("7", 1'b0);
        push_char(CH_SLASH, 1'b0);
        push_char(CH_MINUS, 1'b0);
        push_char("x", 1'b0);
        push_char(8'h00, 1'b0);
        push_char(CH_DQUOTE, 1'b0);
        push_char("A", 1'b0);
        push_char(8'h01, 1'b0);
        push_char(CH_SEMI, 1'b0);
        push_char(8'hFF, 1'b0);
        push_char(CH_LF, 1'b0);
        push_char(8'hFF, 1'b0);
        push_char(CH_MINUS, 1'b0);
        push_char(CH_LPAREN, 1'b0);
        push_char(CH_HASH, 1'b0);
        push_char(8'hFF, 1'b1);
        push_char(CH_MINUS, 1'b0);
        push_char(8'h00, 1'b1);
        push_char(CH_DQUOTE, 1'b0);
        push_char(8'h5A, 1'b1);
        wait_drained();

        // random: mostly well-formed tokens with random text, some noise and broken ones
        for (int chunk = 0; chunk < 4; chunk++)
        begin
            chunk_base = char_pending.size();
            while (char_pending.size() - chunk_base < CHUNK_ITEMS)
            begin
                kind_sel = $urandom_range(0, 15);
                case (kind_sel)
                    0:  push_char(CH_LPAREN, 1'b0);
                    1:  push_char(CH_RPAREN, 1'b0);
                    2:  push_char(CH_QUOTE, 1'b0);
                    3:
                    begin
                        push_char(CH_HASH, 1'b0);
                        push_char($urandom_range(0, 1) ? CH_T : CH_F, 1'b0);
                    end
                    4:
                    begin
                        push_char(CH_HASH, 1'b0);
                        push_char(8'($urandom_range(0, 255)), 1'b0);
                    end
                    5, 6:
                    begin
                        if ($urandom_range(0, 2) == 0)
                        begin
                            push_char(CH_MINUS, 1'b0);
                        end
                        push_char(8'(8'h30 + $urandom_range(0, 9)), 1'b0);
                        n = $urandom_range(0, 5);
                        repeat (n)
                        begin
                            kind_sel = $urandom_range(0, 11);
                            c = (kind_sel < 10) ? 8'(8'h30 + kind_sel)
                                                : ((kind_sel == 10) ? CH_DOT : CH_SLASH);
                            push_char(c, 1'b0);
                        end
                    end
                    7, 8:
                    begin
                        c = sym_body_char();
                        if (c < 8'h3A && c >= 8'h30)
                        begin
                            c = "q";
                        end
                        push_char(c, 1'b0);
                        n = $urandom_range(0, 5);
                        repeat (n) push_char(sym_body_char(), 1'b0);
                    end
                    9:
                    begin
                        push_char(CH_DQUOTE, 1'b0);
                        n = $urandom_range(0, 6);
                        repeat (n) push_char(text_char_nq(), 1'b0);
                        push_char(CH_DQUOTE, 1'b0);
                    end
                    10:
                    begin
                        // string cut by a control or high byte
                        push_char(CH_DQUOTE, 1'b0);
                        n = $urandom_range(0, 3);
                        repeat (n) push_char(text_char_nq(), 1'b0);
                        c = $urandom_range(0, 1) ? 8'($urandom_range(8'h00, 8'h1F))
                                                 : 8'($urandom_range(8'h7F, 8'hFF));
                        push_char(c, 1'b0);
                    end
                    11:
                    begin
                        push_char(CH_SEMI, 1'b0);
                        n = $urandom_range(0, 5);
                        repeat (n) push_char(8'($urandom_range(0, 255)), 1'b0);
                        push_char(CH_LF, 1'b0);
                    end
                    12: push_char(8'($urandom_range(0, 255)), 1'b0);
                    13: push_char(8'h00, 1'b0);
                    14:
                    begin
                        push_char(CH_MINUS, 1'b0);
                        push_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
                    end
                    default: push_char(8'($urandom_range(0, 255)), 1'b1);
                endcase
                // separator: whitespace, a paren, nothing, or an end mark
                case ($urandom_range(0, 8))
                    0, 1: push_char(8'h20, 1'b0);
                    2:    push_char(8'($urandom_range(8'h09, 8'h0D)), 1'b0);
                    3:    push_char(CH_RPAREN, 1'b0);
                    4:    push_char(CH_LPAREN, 1'b0);
                    5:    push_char(8'($urandom_range(0, 255)), 1'b1);
                    default: ;
                endcase
            end
            if (chunk == 1)
            begin
                // receiver holds off while the sender keeps offering the chunk
                stall_requests <= stall_requests + 1;
            end
            wait_drained();
        end

        repeat (10) @(negedge clk);
        if (tok_expected.size() != 0)
        begin
            mismatches++;
            $display("%0d expected results never arrived", tok_expected.size());
        end
        $display("sent %0d source beats (%0d end marks): directed cases, then random chunks",
                 beats_sent, eoi_sent);
        $display("%0d token results checked, %0d of them error results, %0d mismatches",
                 results_seen, err_results, mismatches);
        if (mismatches == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: filelist.f
sv/stok_pkg.sv
sv/stok_if.sv
sv/sexpr_tokenizer_top.sv
dv/testbench.sv
